### src/sbtl_pkg.sv
`timescale 1ns / 1ps
// sbtl_pkg: request and status codes and the table entry type
// used by sbtl_mem, sbtl_ctrl and sorted_block_table_lookup_core; no dependencies
package sbtl_pkg;

	localparam int KEY_W = 32;
	localparam int OFF_W = 32;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [OFF_W-1:0] off;
	} entry_t;

endpackage

### src/sorted_block_table_lookup_core.sv
`timescale 1ns / 1ps
// sorted translation-block table: sorted insert, binary-search lookup, clear
// top level; depends on sbtl_pkg, sbtl_mem and sbtl_ctrl
//
// usage: drive req_type, guest_addr and host_offset with start high; the request
// transfers on a rising edge where start is high and busy is low. every request
// gives exactly one result, shown on status and found_offset for one cycle while
// done is high; the receiver cannot stall it, so done is the transfer itself.
// busy is low again in the cycle done is high, so a new request may follow at once.
// sequence from request to done, with n valid entries:
//   clear, unused code, full insert, lookup on an empty table: done straight from idle
//   lookup: a binary search, one probe of the shared memory read port per step,
//     ending early on a match
//   insert: a binary search for the insert position pos, then each entry above it moved up
//     (n - pos entries, one read and one write per cycle), then a store of the new entry;
//     on an empty table the store follows the request at once
// the memory port does one read and one write per cycle.
// reset clears the entry count and the sequencer; the table memory is not
// cleared and needs no clearing pass, as only entries below the count are read.
module sorted_block_table_lookup_core #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  req_type,
	input  logic [sbtl_pkg::KEY_W-1:0]  guest_addr,
	input  logic [sbtl_pkg::OFF_W-1:0]  host_offset,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [sbtl_pkg::OFF_W-1:0]  found_offset
);
	import sbtl_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	entry_t        rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;

	sbtl_ctrl #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req_type    (req_type),
		.guest_addr  (guest_addr),
		.host_offset (host_offset),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.found_offset(found_offset),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data)
	);

	sbtl_mem #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

endmodule

### src/sbtl_mem.sv
`timescale 1ns / 1ps
// sbtl_mem: table storage, one write port and one registered read port
// depends on sbtl_pkg for the entry type
module sbtl_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output sbtl_pkg::entry_t  rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  sbtl_pkg::entry_t  wr_data
);
	import sbtl_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

### src/sbtl_ctrl.sv
`timescale 1ns / 1ps
// sbtl_ctrl: request sequencer for search, shift-up insert and clear
// depends on sbtl_pkg; drives the ports of sbtl_mem
module sbtl_ctrl #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [1:0]                req_type,
	input  logic [sbtl_pkg::KEY_W-1:0] guest_addr,
	input  logic [sbtl_pkg::OFF_W-1:0] host_offset,
	output logic                      busy,
	output logic                      done,
	output logic [1:0]                status,
	output logic [sbtl_pkg::OFF_W-1:0] found_offset,
	output logic                      rd_en,
	output logic [AW-1:0]             rd_addr,
	input  sbtl_pkg::entry_t          rd_data,
	output logic                      wr_en,
	output logic [AW-1:0]             wr_addr,
	output sbtl_pkg::entry_t          wr_data
);
	import sbtl_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOOK  = 3'd1;
	localparam logic [2:0] S_FIND  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_PUT   = 3'd4;

	localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

	logic [2:0]       state_q;
	logic [AW-1:0]    count_q;
	logic [AW-1:0]    left_q;
	logic [AW-1:0]    rp1_q;
	logic [AW-1:0]    mid_q;
	logic [AW-1:0]    sh_q;
	logic [KEY_W-1:0] key_q;
	logic [OFF_W-1:0] off_q;
	logic             done_q;
	logic [1:0]       status_q;
	logic [OFF_W-1:0] found_q;

	logic          accept;
	logic          full;
	logic          eq;
	logic          gt;
	logic [AW-1:0] nl;
	logic [AW-1:0] nr;
	logic          cont;
	logic [AW-1:0] base_l;
	logic [AW-1:0] base_r;
	logic          is_look;
	logic [AW:0]   mid_sum;
	logic [AW-1:0] mid_w;

	assign accept = start && (state_q == S_IDLE);
	assign full   = (({1'b0, count_q} + (AW+1)'(1)) >= DEPTH_W);

	// the same key compares serve both the exact search and the lower-bound search
	assign eq   = (rd_data.key == key_q);
	assign gt   = (key_q > rd_data.key);
	assign nl   = gt ? (mid_q + AW'(1)) : left_q;
	assign nr   = gt ? rp1_q : mid_q;
	assign cont = (nl < nr);

	always_comb begin
		if (state_q == S_IDLE) begin
			base_l  = '0;
			base_r  = count_q;
			is_look = (req_type == REQ_LOOKUP);
		end else begin
			base_l  = nl;
			base_r  = nr;
			is_look = (state_q == S_LOOK);
		end
		// lookup midpoint is (left+right)/2 with right held as right+1
		mid_sum = {1'b0, base_l} + {1'b0, base_r} - (is_look ? (AW+1)'(1) : '0);
		mid_w   = mid_sum[AW:1];
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mid_w;
		wr_en   = 1'b0;
		wr_addr = left_q;
		wr_data = '{key: key_q, off: off_q};
		case (state_q)
			S_IDLE: begin
				if (accept && (count_q != '0)) begin
					if (req_type == REQ_LOOKUP || (req_type == REQ_INSERT && !full)) begin
						rd_en = 1'b1;
					end
				end
			end
			S_LOOK: begin
				rd_en = !eq && cont;
			end
			S_FIND: begin
				if (cont) begin
					rd_en = 1'b1;
				end else if (nl != count_q) begin
					rd_en   = 1'b1;
					rd_addr = count_q - AW'(1);
				end
			end
			S_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = sh_q + AW'(1);
				wr_data = rd_data;
				if (sh_q != left_q) begin
					rd_en   = 1'b1;
					rd_addr = sh_q - AW'(1);
				end
			end
			S_PUT: begin
				wr_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type == REQ_LOOKUP) begin
							if (count_q == '0) begin
								done_q <= 1'b1;
							end else begin
								state_q <= S_LOOK;
							end
						end else if (req_type == REQ_INSERT) begin
							if (full) begin
								done_q <= 1'b1;
							end else if (count_q == '0) begin
								state_q <= S_PUT;
							end else begin
								state_q <= S_FIND;
							end
						end else begin
							if (req_type == REQ_CLEAR) begin
								count_q <= '0;
							end
							done_q <= 1'b1;
						end
					end
				end
				S_LOOK: begin
					if (eq || !cont) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FIND: begin
					if (!cont) begin
						state_q <= (nl == count_q) ? S_PUT : S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (sh_q == left_q) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					count_q <= count_q + AW'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// search bounds, pointers and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				key_q    <= guest_addr;
				off_q    <= host_offset;
				left_q   <= '0;
				rp1_q    <= count_q;
				mid_q    <= mid_w;
				found_q  <= '0;
				status_q <= ST_OK;
				if (req_type == REQ_LOOKUP) begin
					status_q <= ST_MISS;
				end else if (req_type == REQ_INSERT && full) begin
					status_q <= ST_FULL;
				end
			end
			S_LOOK: begin
				if (eq) begin
					status_q <= ST_OK;
					found_q  <= rd_data.off;
				end
				left_q <= nl;
				rp1_q  <= nr;
				mid_q  <= mid_w;
			end
			S_FIND: begin
				left_q <= nl;
				rp1_q  <= nr;
				mid_q  <= mid_w;
				sh_q   <= count_q - AW'(1);
			end
			S_SHIFT: begin
				sh_q <= sh_q - AW'(1);
			end
			default: begin
				sh_q <= sh_q;
			end
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign found_offset = found_q;

	// shift-up reads run two entries below the write, never on the same entry
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("read and write hit the same entry");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, count_q} < DEPTH_W))
		else $error("entry count past table capacity");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> ((sh_q >= left_q) && (sh_q < count_q)))
		else $error("shift pointer outside the moved range");

	a_put_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |=> (done_q && (status_q == ST_OK)
		&& (count_q == $past(count_q) + AW'(1))))
		else $error("insert did not complete with ok");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while still working");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// testbench for sorted_block_table_lookup_core: a directed table, then phased random requests
// checked against a behavioural model of the sorted table; depends on sbtl_pkg and the core
module testbench;
	import sbtl_pkg::*;

	localparam int TABLE_DEPTH = 256;
	localparam logic [1:0] REQ_NOP = 2'd3;
	localparam int RANDOM_ITEMS = 2000;
	localparam int DIRECTED_ROWS = 23;
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 32;
	localparam int CYCLE_LIMIT = 2_000_000;

	typedef enum int {PHASE_FILL, PHASE_MIXED, PHASE_SEARCH} phase_t;

	typedef struct packed {
		logic [1:0]       req;
		logic [KEY_W-1:0] addr;
		logic [OFF_W-1:0] off;
	} request_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [OFF_W-1:0] offset;
	} result_t;

	typedef struct packed {
		logic [1:0]       req;
		logic [KEY_W-1:0] addr;
		logic [OFF_W-1:0] off;
		logic             typed;
		logic [1:0]       exp_status;
		logic [OFF_W-1:0] exp_offset;
	} directed_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [1:0]       req_type = REQ_NOP;
	logic [KEY_W-1:0] guest_addr = '0;
	logic [OFF_W-1:0] host_offset = '0;
	logic             busy;
	logic             done;
	logic [1:0]       status;
	logic [OFF_W-1:0] found_offset;

	// behavioural copy of the table
	logic [KEY_W-1:0] table_keys [TABLE_DEPTH];
	logic [OFF_W-1:0] table_offs [TABLE_DEPTH];
	int               entry_total = 0;

	result_t pending_results [$];
	int      error_count = 0;
	int      cycle_count = 0;
	bit      steady = 1'b0;

	sorted_block_table_lookup_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.guest_addr  (guest_addr),
		.host_offset (host_offset),
		.done        (done),
		.status      (status),
		.found_offset(found_offset)
	);

	always #10 clk = ~clk;

	function automatic result_t apply_request(request_t rq);
		result_t r;
		int      pos;
		int      lo;
		int      hi;
		int      mid;
		bit      hit;
		r.status = ST_OK;
		r.offset = '0;
		case (rq.req)
		REQ_INSERT: begin
			if (entry_total + 1 >= TABLE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// new key lands in front of any equal keys
				pos = 0;
				while (pos < entry_total && table_keys[pos] < rq.addr)
					pos++;
				for (int i = entry_total; i > pos; i--) begin
					table_keys[i] = table_keys[i-1];
					table_offs[i] = table_offs[i-1];
				end
				table_keys[pos] = rq.addr;
				table_offs[pos] = rq.off;
				entry_total++;
			end
		end
		REQ_LOOKUP: begin
			r.status = ST_MISS;
			lo = 0;
			hi = entry_total - 1;
			hit = 1'b0;
			while (!hit && lo <= hi) begin
				mid = (lo + hi) / 2;
				if (rq.addr == table_keys[mid]) begin
					r.status = ST_OK;
					r.offset = table_offs[mid];
					hit = 1'b1;
				end else if (rq.addr > table_keys[mid]) begin
					lo = mid + 1;
				end else begin
					hi = mid - 1;
				end
			end
		end
		REQ_CLEAR: begin
			entry_total = 0;
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key(bit for_lookup);
		int               sel;
		int               base;
		logic [KEY_W-1:0] k;
		sel = $urandom_range(0, 99);
		base = for_lookup ? 55 : 10;
		if (entry_total > 0 && sel < base) begin
			k = table_keys[$urandom_range(0, entry_total - 1)];
		end else if (entry_total > 0 && sel < base + 10) begin
			// neighbours of stored keys probe the search boundaries
			k = table_keys[$urandom_range(0, entry_total - 1)];
			k = $urandom_range(0, 1) ? k + 1 : k - 1;
		end else if (sel < base + 18) begin
			k = $urandom_range(0, 1) ? '0 : '1;
		end else if (sel < base + 45) begin
			k = 32'h4000_0000 | $urandom_range(0, 31);
		end else begin
			k = $urandom;
		end
		return k;
	endfunction

	function automatic request_t make_request(phase_t ph);
		request_t rq;
		int       sel;
		int       w_ins;
		int       w_look;
		int       w_clr;
		sel = $urandom_range(0, 99);
		case (ph)
		PHASE_FILL: begin
			w_ins = 88; w_look = 10; w_clr = 0;
		end
		PHASE_SEARCH: begin
			w_ins = 6; w_look = 90; w_clr = 1;
		end
		default: begin
			w_ins = 45; w_look = 45; w_clr = 4;
		end
		endcase
		if (sel < w_ins)
			rq.req = REQ_INSERT;
		else if (sel < w_ins + w_look)
			rq.req = REQ_LOOKUP;
		else if (sel < w_ins + w_look + w_clr)
			rq.req = REQ_CLEAR;
		else
			rq.req = REQ_NOP;
		rq.addr = (rq.req == REQ_INSERT || rq.req == REQ_LOOKUP) ?
			pick_key(rq.req == REQ_LOOKUP) : $urandom;
		case ($urandom_range(0, 9))
		0:       rq.off = '0;
		1:       rq.off = '1;
		default: rq.off = $urandom;
		endcase
		return rq;
	endfunction

	// one request transfer; the expectation is queued at the accepting edge
	task automatic transfer_request(request_t rq, logic typed, result_t typed_res);
		int      gap;
		result_t predicted;
		gap = steady ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= rq.req;
		guest_addr <= rq.addr;
		host_offset <= rq.off;
		do
			@(posedge clk);
		while (busy);
		predicted = apply_request(rq);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d found_offset %h", status, found_offset);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					error_count++;
				end
				if (found_offset !== want.offset) begin
					$error("found_offset: expected %h, got %h", want.offset, found_offset);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL sorted_block_table_lookup_core");
			$finish;
		end
	end

	initial begin
		directed_row_t rows [DIRECTED_ROWS];
		request_t      rq;
		result_t       res;
		phase_t        ph;
		int            seg_len;
		int            issued;

		rows[0]  = '{REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_MISS, 32'h0};
		rows[1]  = '{REQ_NOP,    32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b1, ST_OK,   32'h0};
		rows[2]  = '{REQ_CLEAR,  32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK,   32'h0};
		rows[3]  = '{REQ_INSERT, 32'h8000_0000, 32'h0000_1234, 1'b1, ST_OK,   32'h0};
		rows[4]  = '{REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_OK,   32'h0};
		rows[5]  = '{REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_OK,   32'h0};
		rows[6]  = '{REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_OK,   32'h0};
		rows[7]  = '{REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK,   32'hFFFF_FFFF};
		rows[8]  = '{REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1, ST_OK,   32'h0000_1234};
		rows[9]  = '{REQ_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, ST_MISS, 32'h0};
		// equal keys stack up in front of each other
		rows[10] = '{REQ_INSERT, 32'h8000_0000, 32'hAAAA_5555, 1'b1, ST_OK,   32'h0};
		rows[11] = '{REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b0, ST_OK,   32'h0};
		rows[12] = '{REQ_INSERT, 32'h8000_0000, 32'h5555_AAAA, 1'b1, ST_OK,   32'h0};
		rows[13] = '{REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b0, ST_OK,   32'h0};
		rows[14] = '{REQ_LOOKUP, 32'h8000_0001, 32'h0000_0000, 1'b1, ST_MISS, 32'h0};
		rows[15] = '{REQ_INSERT, 32'h0000_0010, 32'h0000_0010, 1'b0, ST_OK,   32'h0};
		rows[16] = '{REQ_LOOKUP, 32'h0000_0010, 32'h0000_0000, 1'b0, ST_OK,   32'h0};
		rows[17] = '{REQ_LOOKUP, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, ST_MISS, 32'h0};
		rows[18] = '{REQ_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,   32'h0};
		rows[19] = '{REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1, ST_MISS, 32'h0};
		rows[20] = '{REQ_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_OK,   32'h0};
		rows[21] = '{REQ_INSERT, 32'h0000_0005, 32'h0000_0006, 1'b1, ST_OK,   32'h0};
		rows[22] = '{REQ_LOOKUP, 32'h0000_0005, 32'h0000_0000, 1'b1, ST_OK,   32'h0000_0006};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			steady = ($urandom_range(0, 3) == 0);
			rq.req = rows[i].req;
			rq.addr = rows[i].addr;
			rq.off = rows[i].off;
			res.status = rows[i].exp_status;
			res.offset = rows[i].exp_offset;
			transfer_request(rq, rows[i].typed, res);
		end

		// first segment fills the table past full, later ones are drawn at random
		issued = 0;
		ph = PHASE_FILL;
		seg_len = 300;
		res = '0;
		while (issued < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < seg_len && issued < RANDOM_ITEMS; n++) begin
				rq = make_request(ph);
				transfer_request(rq, 1'b0, res);
				if (rq.req != REQ_NOP)
					issued++;
			end
			case ($urandom_range(0, 9))
			0, 1: begin
				ph = PHASE_FILL;
				seg_len = 300;
			end
			2, 3, 4: begin
				ph = PHASE_SEARCH;
				seg_len = $urandom_range(30, 150);
			end
			default: begin
				ph = PHASE_MIXED;
				seg_len = $urandom_range(30, 200);
			end
			endcase
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("PASS sorted_block_table_lookup_core");
		else
			$display("FAIL sorted_block_table_lookup_core");
		$finish;
	end

endmodule
